### sv/ufrb_pkg.sv
package ufrb_pkg;

  // FIFO depths and the pointer/index widths that follow from them
  localparam int unsigned RX_DEPTH = 16;
  localparam int unsigned TX_DEPTH = 16;
  localparam int unsigned RX_PTR_W = $clog2(2 * RX_DEPTH);
  localparam int unsigned RX_IDX_W = $clog2(RX_DEPTH);
  localparam int unsigned TX_PTR_W = $clog2(2 * TX_DEPTH);
  localparam int unsigned TX_IDX_W = $clog2(TX_DEPTH);

  // field widths
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned REG_W  = 4;
  localparam int unsigned DATA_W = 16;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned BAUD_W = 15;
  localparam int unsigned FILL_W = 5;

  // register reset values and masks
  localparam logic [15:0] INT_STAT_RST   = 16'h4100;
  localparam logic [5:0]  STAT_CHG_RST   = 6'h06;
  localparam logic [9:0]  BAUD_RST       = 10'h3ff;
  localparam logic [8:0]  FIFO_CTL_MASK  = 9'h19f;
  localparam logic [15:0] INT_CLR_MASK   = 16'h07c0;

  // interrupt status / enable bit positions
  localparam int unsigned ST_RDIS_BIT = 7;
  localparam int unsigned ST_TDIS_BIT = 8;
  localparam int unsigned ST_ERI_BIT  = 10;
  localparam int unsigned EN_SPIE_BIT = 11;
  localparam int unsigned EN_RIE_BIT  = 12;
  localparam int unsigned EN_TIE_BIT  = 13;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_RX     = 2'd2,
    FUNC_TX_POP = 2'd3
  } func_e;

  typedef enum logic [REG_W-1:0] {
    REG_LINE     = 4'd0,
    REG_INT_EN   = 4'd1,
    REG_INT_STAT = 4'd2,
    REG_STAT_CHG = 4'd3,
    REG_FIFO_CTL = 4'd4,
    REG_FLOW     = 4'd5,
    REG_BAUD     = 4'd6,
    REG_TXFIFO   = 4'd7,
    REG_RXFIFO   = 4'd8
  } reg_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [REG_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
    logic [CHAR_W-1:0] rx_char;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [CHAR_W-1:0] tx_char;
    logic              tx_valid;
    logic              tx_stop;
    logic              irq;
    logic              rx_dropped;
    logic              tx_overflow;
    logic [BAUD_W-1:0] baud_divisor;
  } result_t;

endpackage

### sv/ufrb_item_if.sv
interface ufrb_item_if;
  logic                         valid;
  logic                         ready;
  logic [ufrb_pkg::FUNC_W-1:0]  func;
  logic [ufrb_pkg::REG_W-1:0]   reg_index;
  logic [ufrb_pkg::DATA_W-1:0]  write_data;
  logic [ufrb_pkg::CHAR_W-1:0]  rx_char;

  modport source (output valid, func, reg_index, write_data, rx_char, input ready);
  modport sink   (input valid, func, reg_index, write_data, rx_char, output ready);
endinterface

### sv/ufrb_result_if.sv
interface ufrb_result_if;
  logic                         valid;
  logic                         ready;
  logic [ufrb_pkg::DATA_W-1:0]  read_data;
  logic [ufrb_pkg::CHAR_W-1:0]  tx_char;
  logic                         tx_valid;
  logic                         tx_stop;
  logic                         irq;
  logic                         rx_dropped;
  logic                         tx_overflow;
  logic [ufrb_pkg::BAUD_W-1:0]  baud_divisor;

  modport source (output valid, read_data, tx_char, tx_valid, tx_stop, irq, rx_dropped,
                  tx_overflow, baud_divisor, input ready);
  modport sink   (input valid, read_data, tx_char, tx_valid, tx_stop, irq, rx_dropped,
                  tx_overflow, baud_divisor, output ready);
endinterface

### sv/uart_fifo_register_block.sv
// Register side of a UART with 16-entry receive and transmit FIFOs.
// item_i carries one event per item: a bus read, a bus write, a character
// from the serial line, or the line taking the next transmit character
// (func selects which; reg_index, write_data, rx_char as needed).
// result_o returns exactly one result per item: read data, the popped
// transmit character with its valid/stop flags, the level interrupt, the
// rx-drop and tx-overflow flags, and the current baud divisor.
// The result is registered: out_q holds it, or skid_q first on a stall.
// Throughput: one item per cycle while item_i.ready is high; all
// register, FIFO pointer and flag updates finish in the accept cycle,
// so consecutive items see each other's effects with no bubble.
// Stall: results sit in a two-entry output buffer (output register plus a
// skid register). item_i.ready drops only while the skid register is full,
// so one more item is taken while a result waits on a stalled receiver.
// Reset (rst_ni low, async): pointers empty both FIFOs, registers take
// their reset values, the output buffer is emptied. FIFO contents are not
// cleared; reading an entry never written returns an undefined byte.
module uart_fifo_register_block (
  input  logic          clk_i,
  input  logic          rst_ni,
  ufrb_item_if.sink     item_i,
  ufrb_result_if.source result_o
);

  ufrb_pkg::item_t   item;
  ufrb_pkg::result_t res;
  logic              accept;

  logic              out_vld_q, skid_vld_q;
  ufrb_pkg::result_t out_q, skid_q;

  assign item.func       = item_i.func;
  assign item.reg_index  = item_i.reg_index;
  assign item.write_data = item_i.write_data;
  assign item.rx_char    = item_i.rx_char;

  // take a new item unless the skid register is holding a result
  assign item_i.ready = !skid_vld_q;
  assign accept       = item_i.valid && !skid_vld_q;

  ufrb_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .result_o (res)
  );

  // output buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || result_o.ready) begin
      out_vld_q  <= skid_vld_q || accept;
      skid_vld_q <= 1'b0;
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || result_o.ready) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.read_data    = out_q.read_data;
  assign result_o.tx_char      = out_q.tx_char;
  assign result_o.tx_valid     = out_q.tx_valid;
  assign result_o.tx_stop      = out_q.tx_stop;
  assign result_o.irq          = out_q.irq;
  assign result_o.rx_dropped   = out_q.rx_dropped;
  assign result_o.tx_overflow  = out_q.tx_overflow;
  assign result_o.baud_divisor = out_q.baud_divisor;

endmodule

### sv/ufrb_regs.sv
module ufrb_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ufrb_pkg::item_t   item_i,
  output ufrb_pkg::result_t result_o
);

  localparam int unsigned RPW = ufrb_pkg::RX_PTR_W;
  localparam int unsigned TPW = ufrb_pkg::TX_PTR_W;
  localparam int unsigned RIW = ufrb_pkg::RX_IDX_W;
  localparam int unsigned TIW = ufrb_pkg::TX_IDX_W;

  // pointer helpers: pointers wrap at twice the depth
  function automatic logic [RPW-1:0] rx_inc(input logic [RPW-1:0] p);
    return (p == RPW'(2 * ufrb_pkg::RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TPW-1:0] tx_inc(input logic [TPW-1:0] p);
    return (p == TPW'(2 * ufrb_pkg::TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RIW-1:0] rx_idx(input logic [RPW-1:0] p);
    logic [RPW-1:0] t;
    t = (p >= RPW'(ufrb_pkg::RX_DEPTH)) ? p - RPW'(ufrb_pkg::RX_DEPTH) : p;
    return t[RIW-1:0];
  endfunction

  function automatic logic [TIW-1:0] tx_idx(input logic [TPW-1:0] p);
    logic [TPW-1:0] t;
    t = (p >= TPW'(ufrb_pkg::TX_DEPTH)) ? p - TPW'(ufrb_pkg::TX_DEPTH) : p;
    return t[TIW-1:0];
  endfunction

  function automatic logic [RPW-1:0] rx_cnt(input logic [RPW-1:0] wr, input logic [RPW-1:0] rd);
    logic [RPW:0] d;
    d = {1'b0, wr} - {1'b0, rd};
    if (wr < rd) d = d + (RPW+1)'(2 * ufrb_pkg::RX_DEPTH);
    return d[RPW-1:0];
  endfunction

  function automatic logic [TPW-1:0] tx_cnt(input logic [TPW-1:0] wr, input logic [TPW-1:0] rd);
    logic [TPW:0] d;
    d = {1'b0, wr} - {1'b0, rd};
    if (wr < rd) d = d + (TPW+1)'(2 * ufrb_pkg::TX_DEPTH);
    return d[TPW-1:0];
  endfunction

  logic [ufrb_pkg::CHAR_W-1:0] rx_store_q [ufrb_pkg::RX_DEPTH];
  logic [ufrb_pkg::CHAR_W-1:0] tx_store_q [ufrb_pkg::TX_DEPTH];

  logic [RPW-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d;
  logic [TPW-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d;
  logic [15:0]    int_stat_q, int_stat_d;
  logic [5:0]     stat_chg_q, stat_chg_d;
  logic [8:0]     fifo_ctl_q, fifo_ctl_d;
  logic [15:0]    int_en_q, int_en_d;
  logic [9:0]     baud_q, baud_d;

  logic           rx_we, tx_we;
  logic [RPW-1:0] rx_count, rx_count_nx;
  logic [TPW-1:0] tx_count, tx_count_nx;
  logic [4:0]     rx_lvl;

  assign rx_count = rx_cnt(rx_wr_q, rx_rd_q);
  assign tx_count = tx_cnt(tx_wr_q, tx_rd_q);

  always_comb begin
    rx_wr_d    = rx_wr_q;
    rx_rd_d    = rx_rd_q;
    tx_wr_d    = tx_wr_q;
    tx_rd_d    = tx_rd_q;
    int_stat_d = int_stat_q;
    stat_chg_d = stat_chg_q;
    fifo_ctl_d = fifo_ctl_q;
    int_en_d   = int_en_q;
    baud_d     = baud_q;
    rx_we      = 1'b0;
    tx_we      = 1'b0;
    result_o   = '0;
    rx_count_nx = '0;
    tx_count_nx = '0;
    // rx trigger level: 1, 4, 8 or 12
    rx_lvl = {1'b0, fifo_ctl_q[8:7], 2'b00};
    if (rx_lvl == 5'd0) rx_lvl = 5'd1;

    if (accept_i) begin
      case (item_i.func)
        ufrb_pkg::FUNC_READ: begin
          case (item_i.reg_index)
            ufrb_pkg::REG_INT_EN: result_o.read_data = int_en_q;
            ufrb_pkg::REG_INT_STAT: begin
              int_stat_d = {int_stat_q[15:5], ufrb_pkg::FILL_W'(rx_count)};
              result_o.read_data = int_stat_d;
            end
            ufrb_pkg::REG_STAT_CHG: begin
              stat_chg_d[2] = (tx_count < TPW'(ufrb_pkg::TX_DEPTH));
              stat_chg_d[1] = (tx_count == '0);
              result_o.read_data = {10'd0, stat_chg_d};
            end
            ufrb_pkg::REG_FIFO_CTL: result_o.read_data = {7'd0, fifo_ctl_q};
            ufrb_pkg::REG_BAUD:     result_o.read_data = {6'd0, baud_q};
            ufrb_pkg::REG_RXFIFO: begin
              result_o.read_data = {8'd0, rx_store_q[rx_idx(rx_rd_q)]};
              if (rx_count != '0) rx_rd_d = rx_inc(rx_rd_q);
            end
            default: result_o.read_data = '0;
          endcase
        end
        ufrb_pkg::FUNC_WRITE: begin
          case (item_i.reg_index)
            ufrb_pkg::REG_INT_EN:   int_en_d = item_i.write_data;
            ufrb_pkg::REG_INT_STAT: int_stat_d = int_stat_q &
                                      (item_i.write_data | ~ufrb_pkg::INT_CLR_MASK);
            ufrb_pkg::REG_STAT_CHG: stat_chg_d = stat_chg_q & item_i.write_data[5:0] & 6'h3e;
            ufrb_pkg::REG_FIFO_CTL: begin
              if (item_i.write_data[1:0] != 2'b00) begin
                rx_wr_d = '0;
                rx_rd_d = '0;
              end
              if (item_i.write_data[0] || item_i.write_data[2]) begin
                tx_wr_d = '0;
                tx_rd_d = '0;
              end
              fifo_ctl_d = item_i.write_data[8:0] & ufrb_pkg::FIFO_CTL_MASK;
              // software reset
              if (item_i.write_data[15]) begin
                rx_wr_d    = '0;
                rx_rd_d    = '0;
                tx_wr_d    = '0;
                tx_rd_d    = '0;
                int_stat_d = ufrb_pkg::INT_STAT_RST;
                stat_chg_d = ufrb_pkg::STAT_CHG_RST;
                fifo_ctl_d = '0;
                int_en_d   = '0;
                baud_d     = ufrb_pkg::BAUD_RST;
              end
            end
            ufrb_pkg::REG_BAUD: baud_d = item_i.write_data[9:0];
            ufrb_pkg::REG_TXFIFO: begin
              if (tx_count >= TPW'(ufrb_pkg::TX_DEPTH)) begin
                result_o.tx_overflow = 1'b1;
              end else begin
                tx_we   = 1'b1;
                tx_wr_d = tx_inc(tx_wr_q);
              end
            end
            default: ;
          endcase
        end
        ufrb_pkg::FUNC_RX: begin
          if (rx_count >= RPW'(ufrb_pkg::RX_DEPTH)) begin
            result_o.rx_dropped = 1'b1;
          end else begin
            rx_we       = 1'b1;
            rx_wr_d     = rx_inc(rx_wr_q);
            rx_count_nx = rx_count + 1'b1;
            if (ufrb_pkg::FILL_W'(rx_count_nx) >= rx_lvl) int_stat_d[ufrb_pkg::ST_RDIS_BIT] = 1'b1;
          end
        end
        default: begin
          // line takes a transmit character
          if (tx_count != '0) begin
            result_o.tx_char  = tx_store_q[tx_idx(tx_rd_q)];
            result_o.tx_valid = 1'b1;
            tx_rd_d           = tx_inc(tx_rd_q);
            tx_count_nx       = tx_count - 1'b1;
          end
          result_o.tx_stop = (tx_count_nx == '0);
        end
      endcase
    end

    result_o.irq = (int_en_d[ufrb_pkg::EN_RIE_BIT]  && int_stat_d[ufrb_pkg::ST_RDIS_BIT]) ||
                   (int_en_d[ufrb_pkg::EN_TIE_BIT]  && int_stat_d[ufrb_pkg::ST_TDIS_BIT]) ||
                   (int_en_d[ufrb_pkg::EN_SPIE_BIT] && int_stat_d[ufrb_pkg::ST_ERI_BIT]);
    result_o.baud_divisor = ufrb_pkg::BAUD_W'(baud_d[7:0]) << {baud_d[9:8], 1'b1};
  end

  // FIFO stores: no reset
  always_ff @(posedge clk_i) begin
    if (rx_we) rx_store_q[rx_idx(rx_wr_q)] <= item_i.rx_char;
    if (tx_we) tx_store_q[tx_idx(tx_wr_q)] <= item_i.write_data[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wr_q    <= '0;
      rx_rd_q    <= '0;
      tx_wr_q    <= '0;
      tx_rd_q    <= '0;
      int_stat_q <= ufrb_pkg::INT_STAT_RST;
      stat_chg_q <= ufrb_pkg::STAT_CHG_RST;
      fifo_ctl_q <= '0;
      int_en_q   <= '0;
      baud_q     <= ufrb_pkg::BAUD_RST;
    end else begin
      rx_wr_q    <= rx_wr_d;
      rx_rd_q    <= rx_rd_d;
      tx_wr_q    <= tx_wr_d;
      tx_rd_q    <= tx_rd_d;
      int_stat_q <= int_stat_d;
      stat_chg_q <= stat_chg_d;
      fifo_ctl_q <= fifo_ctl_d;
      int_en_q   <= int_en_d;
      baud_q     <= baud_d;
    end
  end

endmodule
